[src/cauchy_gf256_parity_encoder_assert.svh]
// assertion macros shared by the rtl
`ifndef CAUCHY_GF256_PARITY_ENCODER_ASSERT_SVH
`define CAUCHY_GF256_PARITY_ENCODER_ASSERT_SVH

// condition implies consequence in the same cycle
`define CGPE_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cgpe assertion failed");

// condition implies consequence in the next cycle
`define CGPE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cgpe assertion failed");

`endif

[src/cgpe_pkg.sv]
`default_nettype none

package cgpe_pkg;

    // field polynomial x^8+x^4+x^3+x^2+1 and group order
    localparam logic [8:0] GF_POLY        = 9'h11d;
    localparam logic [7:0] GF_ORDER       = 8'd255;
    localparam int         MAX_PARITY_DEF = 32;
    localparam int         CFG_DATA_W     = 8;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_GEN_SIZE     = 1'b0,
        CFG_PARITY_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] symbol_index;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [4:0] parity_row;
        logic [7:0] parity_byte;
        logic       last_of_run;
    } out_item_t;

    typedef logic [255:0][7:0] gf_tab_t;

    // shift-and-add multiply in gf(256)
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] p;
        x = {1'b0, a};
        p = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                p = p ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8])
            begin
                x = x ^ GF_POLY;
            end
        end
        return p;
    endfunction

    // inverse as a^254, zero maps to zero; evaluated at elaboration
    function automatic gf_tab_t build_gf_inv_tab();
        gf_tab_t    tab;
        logic [7:0] base;
        logic [7:0] res;
        for (int a = 0; a < 256; a++)
        begin
            base = 8'(a);
            res  = 8'd1;
            for (int k = 0; k < 7; k++)
            begin
                base = gf_mul(base, base);
                res  = gf_mul(res, base);
            end
            tab[a] = res;
        end
        return tab;
    endfunction

    localparam gf_tab_t GF_INV_TAB = build_gf_inv_tab();

endpackage

`default_nettype wire

[src/cauchy_gf256_parity_encoder.sv]
`default_nettype none
// Cauchy parity encoder over GF(256), polynomial 0x11d.
// Input channel item/item_valid/item_ready carries one data byte per beat,
// column by column: symbol 0 up to gen_size-1 of one byte position.
// Output channel parity/parity_valid/parity_ready carries one coded byte
// per beat, rows 0 to r-1 in order, last_of_run set on row r-1, where
// r = min(parity_count, MAX_PARITY, 255 - gen_size).
// Config: cfg_we writes cfg_wdata into register cfg_index (0 gen_size,
// 1 parity_count), to be written only while the block is idle.
// Throughput: one input beat per cycle, save for the wait below; all rows update in parallel, each
// through an inverse table lookup and a gf multiply per cycle.
// A last-symbol beat waits in the input stage while the previous column's
// parity rows are still being drained.
// A finished column passes from the accumulators to the snapshot registers and then the output register.
// Reset clears control state and config (gen_size 1, parity_count 0);
// accumulators hold garbage until a symbol-0 beat clears them.
// An output stall only holds the output register and the drain buffer;
// non-final beats of the next column keep flowing.
module cauchy_gf256_parity_encoder
    import cgpe_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire in_item_t              item,
    output logic                       parity_valid,
    input  wire logic                  parity_ready,
    output out_item_t                  parity,
    input  wire logic                  cfg_we,
    input  wire cfg_reg_t              cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    `include "cauchy_gf256_parity_encoder_assert.svh"

    localparam int ROW_W = $clog2(MAX_PARITY + 1);
    localparam int IDX_W = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

    logic [7:0]       gen_size_reg;
    logic [5:0]       parity_count_reg;
    logic [ROW_W-1:0] rows;
    logic [7:0]       last_sym;

    logic             s1_valid_reg;
    in_item_t         s1_reg;
    logic             s1_emit;
    logic             s1_fire;

    logic [7:0]       acc_reg [MAX_PARITY];
    logic [7:0]       acc_next [MAX_PARITY];
    logic [7:0]       snap_reg [MAX_PARITY];

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic             load_out;

    logic             out_valid_reg;
    out_item_t        out_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_size_reg     <= 8'd1;
            parity_count_reg <= 6'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GEN_SIZE:     gen_size_reg     <= cfg_wdata[7:0];
                CFG_PARITY_COUNT: parity_count_reg <= cfg_wdata[5:0];
            endcase
        end
    end

    // effective row count and last symbol of a column
    always_comb
    begin
        logic [8:0] r9;
        logic [8:0] room;
        r9   = {3'd0, parity_count_reg};
        room = {1'b0, GF_ORDER - gen_size_reg};
        if (r9 > 9'(MAX_PARITY))
        begin
            r9 = 9'(MAX_PARITY);
        end
        if (r9 > room)
        begin
            r9 = room;
        end
        rows     = ROW_W'(r9);
        last_sym = gen_size_reg - 8'd1;
    end

    // input stage handshake
    assign s1_emit    = (s1_reg.symbol_index == last_sym) && (rows != '0);
    assign s1_fire    = s1_valid_reg && (!s1_emit || !busy_reg);
    assign item_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_reg <= item;
        end
    end

    // per-row accumulate: clear on symbol 0, add inv((gen_size+j)^sym)*byte
    always_comb
    begin
        logic [7:0] coef_idx;
        for (int j = 0; j < MAX_PARITY; j++)
        begin
            coef_idx    = (gen_size_reg + 8'(j)) ^ s1_reg.symbol_index;
            acc_next[j] = (s1_reg.symbol_index == 8'd0) ? 8'd0 : acc_reg[j];
            if (ROW_W'(j) < rows)
            begin
                acc_next[j] = acc_next[j] ^ gf_mul(GF_INV_TAB[coef_idx], s1_reg.data_byte);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                acc_reg[j] <= acc_next[j];
            end
        end
    end

    // snapshot of a finished column for draining
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit)
        begin
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                snap_reg[j] <= acc_next[j];
            end
            last_idx_reg <= IDX_W'(rows - ROW_W'(1));
        end
    end

    assign load_out = busy_reg && (!out_valid_reg || parity_ready);

    // drain control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (s1_fire && s1_emit)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (load_out)
        begin
            if (idx_reg == last_idx_reg)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (parity_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.parity_row  <= 5'(idx_reg);
            out_reg.parity_byte <= snap_reg[idx_reg];
            out_reg.last_of_run <= (idx_reg == last_idx_reg);
        end
    end

    assign parity_valid = out_valid_reg;
    assign parity       = out_reg;

    // drain ends right after its final row is loaded
    `CGPE_ASSERT_NEXT(a_drain_end, load_out && (idx_reg == last_idx_reg), !busy_reg)
    // drain index never passes the final row
    `CGPE_ASSERT_SAME(a_idx_range, busy_reg, idx_reg <= last_idx_reg)
    // a finished column waits while the previous one drains
    `CGPE_ASSERT_SAME(a_emit_stall, s1_valid_reg && s1_emit && busy_reg, !item_ready)
    // a loaded row shows up on the output
    `CGPE_ASSERT_NEXT(a_load_shows, load_out, parity_valid)

endmodule

`default_nettype wire

[tb/cgpe_parity_monitor.sv]
`default_nettype none

module cgpe_parity_monitor
    import cgpe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire logic                  item_ready,
    input  wire in_item_t              item,
    input  wire logic                  parity_valid,
    input  wire logic                  parity_ready,
    input  wire out_item_t             parity,
    input  wire logic                  cfg_we,
    input  wire cfg_reg_t              cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         errors,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = MAX_PARITY_DEF;

    // exp table doubled so that a sum of two logs needs no reduction
    logic [7:0] gf_exp [0:509];
    logic [7:0] gf_log [0:255];

    // shadow of the block's registers and row accumulators
    logic [7:0] gen_size_q     = 8'd1;
    logic [5:0] parity_count_q = 6'd0;
    logic [7:0] row_acc [ROWS];

    // coded bytes still owed by the block, oldest first
    out_item_t  parity_due [$];

    initial
    begin
        logic [8:0] x;
        x = 9'd1;
        for (int i = 0; i < 255; i++)
        begin
            gf_exp[i]        = x[7:0];
            gf_exp[i + 255]  = x[7:0];
            gf_log[x[7:0]]   = 8'(i);
            x = {x[7:0], 1'b0};
            if (x[8])
            begin
                x = x ^ 9'h11d;
            end
        end
        gf_log[0] = 8'd0;
        foreach (row_acc[k])
        begin
            row_acc[k] = 8'd0;
        end
    end

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        if (a == 8'd0 || b == 8'd0)
        begin
            return 8'd0;
        end
        return gf_exp[int'(gf_log[a]) + int'(gf_log[b])];
    endfunction

    // zero has no inverse and counts as a zero coefficient
    function automatic logic [7:0] gf_recip(input logic [7:0] a);
        if (a == 8'd0)
        begin
            return 8'd0;
        end
        return gf_exp[255 - int'(gf_log[a])];
    endfunction

    // fold one data beat into the rows, queue the column on its last symbol
    function automatic void absorb_beat(input in_item_t beat);
        int         rows;
        int         room;
        logic [7:0] x;
        out_item_t  res;
        rows = int'(parity_count_q);
        if (rows > ROWS)
        begin
            rows = ROWS;
        end
        room = 255 - int'(gen_size_q);
        if (rows > room)
        begin
            rows = room;
        end
        if (beat.symbol_index == 8'd0)
        begin
            foreach (row_acc[k])
            begin
                row_acc[k] = 8'd0;
            end
        end
        for (int j = 0; j < rows; j++)
        begin
            x = 8'(int'(gen_size_q) + j) ^ beat.symbol_index;
            row_acc[j] = row_acc[j] ^ gf_times(gf_recip(x), beat.data_byte);
        end
        if (beat.symbol_index == 8'(gen_size_q - 8'd1))
        begin
            for (int j = 0; j < rows; j++)
            begin
                res.parity_row  = 5'(j);
                res.parity_byte = row_acc[j];
                res.last_of_run = (j == rows - 1);
                parity_due.push_back(res);
            end
        end
    endfunction

    // watch config writes, input beats and parity beats
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t due;
        if (!rst_n)
        begin
            gen_size_q     = 8'd1;
            parity_count_q = 6'd0;
            parity_due.delete();
            errors         = 0;
            pending        = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_GEN_SIZE)
                begin
                    gen_size_q = cfg_wdata;
                end
                else if (cfg_index == CFG_PARITY_COUNT)
                begin
                    parity_count_q = cfg_wdata[5:0];
                end
            end

            if (item_valid && item_ready)
            begin
                absorb_beat(item);
            end

            if (parity_valid && parity_ready)
            begin
                if (parity_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected parity beat, expected none, got row %0d byte %02h last %0b",
                             $time, parity.parity_row, parity.parity_byte, parity.last_of_run);
                end
                else
                begin
                    due = parity_due.pop_front();
                    if (parity.parity_row != due.parity_row)
                    begin
                        errors++;
                        $display("%0t: parity_row expected %0d got %0d",
                                 $time, due.parity_row, parity.parity_row);
                    end
                    if (parity.parity_byte != due.parity_byte)
                    begin
                        errors++;
                        $display("%0t: parity_byte of row %0d expected %02h got %02h",
                                 $time, due.parity_row, due.parity_byte, parity.parity_byte);
                    end
                    if (parity.last_of_run != due.last_of_run)
                    begin
                        errors++;
                        $display("%0t: last_of_run of row %0d expected %0b got %0b",
                                 $time, due.parity_row, due.last_of_run, parity.last_of_run);
                    end
                end
            end

            pending = parity_due.size();
        end
    end

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
    import cgpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    in_item_t              item;
    logic                  parity_valid;
    logic                  parity_ready;
    out_item_t             parity;
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int                    errors;
    int                    pending;
    int                    beats_sent = 0;
    bit                    calm       = 1'b0;

    cauchy_gf256_parity_encoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .parity_valid (parity_valid),
        .parity_ready (parity_ready),
        .parity       (parity),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    cgpe_parity_monitor i_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .parity_valid (parity_valid),
        .parity_ready (parity_ready),
        .parity       (parity),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // safety net against a hung handshake
    initial
    begin
        #72_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 55)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            return 8'h00;
        end
        if (roll < 20)
        begin
            return 8'hff;
        end
        return 8'($urandom_range(255));
    endfunction

    // one input beat, held until accepted
    task automatic send_beat(input logic [7:0] sym, input logic [7:0] data);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{symbol_index: sym, data_byte: data};
        do @(posedge clk); while (!item_ready);
        beats_sent++;
    endtask

    // stop sending until every coded byte is out and the block is quiet
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    // write both registers while idle
    task automatic set_config(input logic [7:0] gen_size, input logic [7:0] parity_count);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GEN_SIZE;
        cfg_wdata <= gen_size;
        @(posedge clk);
        cfg_index <= CFG_PARITY_COUNT;
        cfg_wdata <= parity_count;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: ready bursts broken by stalls
    initial
    begin
        int burst;
        int hold;
        parity_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            burst = $urandom_range(1, 16);
            parity_ready <= 1'b1;
            repeat (burst) @(posedge clk);
            hold = idle_len();
            if (hold > 0)
            begin
                parity_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int gs;
        int pc;
        int roll;
        int cols;
        int cut;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_GEN_SIZE;
        cfg_wdata  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // reset values: one symbol, no coded rows
        send_beat(8'd0, 8'h00);

        // short column, all-ones and single-bit bytes
        set_config(8'd3, 8'd4);
        send_beat(8'd0, 8'hff);
        send_beat(8'd1, 8'h80);
        send_beat(8'd2, 8'h01);

        // every row, one-symbol columns
        set_config(8'd1, 8'd32);
        send_beat(8'd0, 8'ha5);
        send_beat(8'd0, 8'h5a);

        // no room for rows; upper bits of the count are dropped
        set_config(8'd255, 8'hc5);
        send_beat(8'd0, 8'h3c);
        send_beat(8'd254, 8'hc3);

        // zero gen_size: last symbol wraps to 255, count clamps to 32
        set_config(8'd0, 8'd33);
        send_beat(8'd0, 8'h11);
        send_beat(8'd255, 8'hee);

        // one row left, zero coefficient on an out-of-range symbol
        set_config(8'd254, 8'd40);
        send_beat(8'd0, 8'h7e);
        send_beat(8'd254, 8'h81);

        // out-of-range symbols, some hitting a zero coefficient
        set_config(8'd2, 8'd6);
        send_beat(8'd0, 8'h0b);
        send_beat(8'd2, 8'hd4);
        send_beat(8'd7, 8'h99);
        send_beat(8'd200, 8'hff);
        send_beat(8'd1, 8'h40);

        // rows added in the middle of a column
        set_config(8'd4, 8'd2);
        send_beat(8'd0, 8'h12);
        send_beat(8'd1, 8'h34);
        set_config(8'd4, 8'd6);
        send_beat(8'd2, 8'h56);
        send_beat(8'd3, 8'h78);

        // rows dropped in the middle of a column
        set_config(8'd5, 8'd8);
        send_beat(8'd0, 8'h9a);
        send_beat(8'd1, 8'hbc);
        send_beat(8'd2, 8'hde);
        set_config(8'd5, 8'd3);
        send_beat(8'd3, 8'hf0);
        send_beat(8'd4, 8'h0f);

        // random phases of whole columns with some noise and broken ones
        while (beats_sent < 410)
        begin
            calm = ($urandom_range(99) < 20);
            roll = $urandom_range(99);
            if (roll < 85)
            begin
                gs = $urandom_range(1, 10);
            end
            else if (roll < 95)
            begin
                gs = $urandom_range(11, 40);
            end
            else
            begin
                gs = $urandom_range(200, 255);
            end
            roll = $urandom_range(99);
            if (roll < 10)
            begin
                pc = 0;
            end
            else if (roll < 20)
            begin
                pc = $urandom_range(32, 63);
            end
            else
            begin
                pc = $urandom_range(1, 31);
            end
            set_config(8'(gs), 8'(pc));
            cols = (gs > 40) ? 1 : $urandom_range(1, 4);
            repeat (cols)
            begin
                cut = ($urandom_range(99) < 6) ? $urandom_range(0, gs - 1) : gs;
                for (int s = 0; s < cut; s++)
                begin
                    if (s > 0 && s == gs / 2 && $urandom_range(99) < 8)
                    begin
                        set_config(8'(gs), 8'($urandom_range(0, 40)));
                    end
                    if ($urandom_range(99) < 4)
                    begin
                        send_beat(8'($urandom_range(255)), pick_byte());
                    end
                    send_beat(8'(s), pick_byte());
                end
                if ($urandom_range(99) < 10)
                begin
                    settle();
                end
            end
        end

        // drain and decide
        calm = 1'b0;
        item_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
